// ----- rtl/wsfb_pkg.sv -----
// Shared types, constants and helpers for the WebSocket frame builder.
package wsfb_pkg;

  localparam logic [7:0]  FRAME_HDR0  = 8'h81;   // FIN plus text opcode
  localparam logic [7:0]  MASK_BIT    = 8'h80;
  localparam logic [63:0] LEN7_MAX    = 64'd125;
  localparam logic [63:0] LEN16_MAX   = 64'd65535;
  localparam logic [6:0]  LEN16_CODE  = 7'd126;
  localparam logic [6:0]  LEN64_CODE  = 7'd127;
  localparam int          HDR_IDX_W   = 4;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    LC_7  = 2'd0,
    LC_16 = 2'd1,
    LC_64 = 2'd2
  } len_class_t;

  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [63:0] len;
    logic [31:0] key;
    logic [7:0]  pbyte;
    len_class_t  lclass;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       unexpected_byte;
  } result_t;

  // Header position of the first mask key byte for each length form.
  function automatic hdr_idx_t key_start(len_class_t lc);
    hdr_idx_t ks;
    case (lc)
      LC_7:    ks = hdr_idx_t'(2);
      LC_16:   ks = hdr_idx_t'(4);
      LC_64:   ks = hdr_idx_t'(10);
      default: ks = hdr_idx_t'(2);
    endcase
    return ks;
  endfunction

  // Mask key byte, byte 0 in bits 31..24.
  function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      2'd3:    b = key[7:0];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/wsfb_in_if.sv -----
// Input channel interface: command, length, key and payload byte.
interface wsfb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] frame_len;
  logic [31:0] mask_key;
  logic [7:0]  payload_byte;

  modport source (output valid, command, frame_len, mask_key, payload_byte,
                  input ready);
  modport sink   (input valid, command, frame_len, mask_key, payload_byte,
                  output ready);
endinterface

// ----- rtl/wsfb_out_if.sv -----
// Result channel interface: one framed output byte per transfer.
interface wsfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_frame;
  logic       unexpected_byte;

  modport source (output valid, out_byte, last_of_frame, unexpected_byte,
                  input ready);
  modport sink   (input valid, out_byte, last_of_frame, unexpected_byte,
                  output ready);
endinterface

// ----- rtl/wsfb_hdr.sv -----
// Header byte selector: picks the frame header byte at a given position.
module wsfb_hdr (
  input  wsfb_pkg::item_t    item,
  input  wsfb_pkg::hdr_idx_t idx,
  output wsfb_pkg::result_t  hdr_res,
  output logic               hdr_done
);

  wsfb_pkg::hdr_idx_t ks;
  wsfb_pkg::hdr_idx_t lsel;
  wsfb_pkg::hdr_idx_t ksel;
  logic [6:0]         len_code;
  logic [7:0]         b;

  always_comb begin
    ks   = wsfb_pkg::key_start(item.lclass);
    lsel = ks - idx - wsfb_pkg::hdr_idx_t'(1);
    ksel = idx - ks;
    case (item.lclass)
      wsfb_pkg::LC_7:  len_code = item.len[6:0];
      wsfb_pkg::LC_16: len_code = wsfb_pkg::LEN16_CODE;
      wsfb_pkg::LC_64: len_code = wsfb_pkg::LEN64_CODE;
      default:         len_code = wsfb_pkg::LEN64_CODE;
    endcase
    if (idx == wsfb_pkg::hdr_idx_t'(0)) begin
      b = wsfb_pkg::FRAME_HDR0;
    end else if (idx == wsfb_pkg::hdr_idx_t'(1)) begin
      b = wsfb_pkg::MASK_BIT | {1'b0, len_code};
    end else if (idx < ks) begin
      // extended length, most significant byte first
      b = 8'(item.len >> {lsel[2:0], 3'b000});
    end else begin
      b = wsfb_pkg::key_byte(item.key, ksel[1:0]);
    end
    hdr_done                = (idx == ks + wsfb_pkg::hdr_idx_t'(3));
    hdr_res.out_byte        = b;
    hdr_res.last_of_frame   = hdr_done && (item.len == 64'd0);
    hdr_res.unexpected_byte = 1'b0;
  end

endmodule

// ----- rtl/wsfb_state.sv -----
// Open-frame state and payload masking.
module wsfb_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_commit,
  input  logic              pay_go,
  input  wsfb_pkg::item_t   item,
  output wsfb_pkg::result_t pay_res,
  output logic              frame_open
);

  logic [31:0] key_store_r,  key_store_nxt;
  logic [63:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  key_index_r,  key_index_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic [63:0] left_dec;

  assign left_dec   = bytes_left_r - 64'd1;
  assign frame_open = frame_open_r;

  always_comb begin
    if (frame_open_r) begin
      pay_res.out_byte        = item.pbyte ^ wsfb_pkg::key_byte(key_store_r, key_index_r);
      pay_res.last_of_frame   = (left_dec == 64'd0);
      pay_res.unexpected_byte = 1'b0;
    end else begin
      pay_res.out_byte        = 8'd0;
      pay_res.last_of_frame   = 1'b0;
      pay_res.unexpected_byte = 1'b1;
    end

    key_store_nxt  = key_store_r;
    bytes_left_nxt = bytes_left_r;
    key_index_nxt  = key_index_r;
    frame_open_nxt = frame_open_r;
    if (start_commit) begin
      key_store_nxt  = item.key;
      bytes_left_nxt = item.len;
      key_index_nxt  = 2'd0;
      frame_open_nxt = (item.len != 64'd0);
    end else if (pay_go && frame_open_r) begin
      key_index_nxt  = key_index_r + 2'd1;
      bytes_left_nxt = left_dec;
      frame_open_nxt = (left_dec != 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_store_r  <= 32'd0;
      bytes_left_r <= 64'd0;
      key_index_r  <= 2'd0;
      frame_open_r <= 1'b0;
    end else begin
      key_store_r  <= key_store_nxt;
      bytes_left_r <= bytes_left_nxt;
      key_index_r  <= key_index_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

// ----- rtl/websocket_frame_builder.sv -----
// Top level of the masked client WebSocket text frame builder.
//
//   channel   dir   payload                                        transfer when
//   in_ch     in    command, frame_len, mask_key, payload_byte       valid & ready
//   out_ch    out   out_byte, last_of_frame, unexpected_byte         valid & ready
//
// A payload item emits one byte; bytes leave one per cycle, back to back, unless the output stalls.
// A start item emits one header byte per cycle unless the output stalls: 6, 8 or
// 14 bytes for the 7-bit, 16-bit and 64-bit length forms.
// rst_n is synchronous and clears the item slot, header counter, output valid
// and frame state. A stalled output holds its byte; the input slot still
// takes a new item in the cycle the held one finishes.
module websocket_frame_builder (
  input logic         clk,
  input logic         rst_n,
  wsfb_in_if.sink     in_ch,
  wsfb_out_if.source  out_ch
);

  // input slot
  logic               in_valid_r, in_valid_nxt;
  wsfb_pkg::item_t    in_item_r;
  wsfb_pkg::item_t    in_item_nxt;
  // header position of the start item in the slot
  wsfb_pkg::hdr_idx_t hdr_idx_r, hdr_idx_nxt;
  // output register
  logic               out_valid_r, out_valid_nxt;
  wsfb_pkg::result_t  out_res_r, out_res_nxt;

  wsfb_pkg::result_t  hdr_res, pay_res;
  logic               hdr_done, frame_open;
  logic               can_emit, is_start, item_done, in_xfer;
  wsfb_pkg::len_class_t lclass_in;

  wsfb_hdr u_hdr (
    .item     (in_item_r),
    .idx      (hdr_idx_r),
    .hdr_res  (hdr_res),
    .hdr_done (hdr_done)
  );

  wsfb_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_commit (item_done && is_start),
    .pay_go       (item_done && !is_start),
    .item         (in_item_r),
    .pay_res      (pay_res),
    .frame_open   (frame_open)
  );

  // Emit a byte whenever the slot holds work and the output register frees up.
  assign can_emit  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign is_start  = (in_item_r.cmd == wsfb_pkg::CMD_START);
  assign item_done = can_emit && (!is_start || hdr_done);
  assign in_xfer   = in_ch.valid && in_ch.ready;

  assign in_ch.ready            = !in_valid_r || item_done;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = out_res_r.out_byte;
  assign out_ch.last_of_frame   = out_res_r.last_of_frame;
  assign out_ch.unexpected_byte = out_res_r.unexpected_byte;

  always_comb begin
    // classify the length on the way in to keep the header path short
    if (in_ch.frame_len <= wsfb_pkg::LEN7_MAX) begin
      lclass_in = wsfb_pkg::LC_7;
    end else if (in_ch.frame_len <= wsfb_pkg::LEN16_MAX) begin
      lclass_in = wsfb_pkg::LC_16;
    end else begin
      lclass_in = wsfb_pkg::LC_64;
    end

    in_item_nxt  = in_item_r;
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_item_nxt.cmd    = wsfb_pkg::cmd_t'(in_ch.command);
      in_item_nxt.len    = in_ch.frame_len;
      in_item_nxt.key    = in_ch.mask_key;
      in_item_nxt.pbyte  = in_ch.payload_byte;
      in_item_nxt.lclass = lclass_in;
      in_valid_nxt       = 1'b1;
    end else if (item_done) begin
      in_valid_nxt = 1'b0;
    end

    // advance through the header, restart at zero once it is out
    hdr_idx_nxt = hdr_idx_r;
    if (can_emit && is_start) begin
      hdr_idx_nxt = hdr_done ? wsfb_pkg::hdr_idx_t'(0)
                             : hdr_idx_r + wsfb_pkg::hdr_idx_t'(1);
    end

    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (can_emit) begin
      out_res_nxt   = is_start ? hdr_res : pay_res;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      hdr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  // A header in progress always belongs to a start item held in the slot.
  a_hdr_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_idx_r != '0) |-> (in_valid_r && is_start))
    else $error("header position set without a start item in the slot");

  // The longest header has fourteen bytes.
  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= wsfb_pkg::hdr_idx_t'(13))
    else $error("header position past the longest header");

  // A dropped byte is reported as a zero byte that closes nothing.
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.unexpected_byte) |->
      (out_res_r.out_byte == 8'd0 && !out_res_r.last_of_frame))
    else $error("dropped byte result carries data or last flag");

  // A payload byte that closes the frame leaves no frame open.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (item_done && !is_start && pay_res.last_of_frame) |=> !frame_open)
    else $error("frame still open after its last payload byte");

endmodule
